// ----- rtl/tts_pkg.sv -----
// Shared types and constants of the time-triggered task scheduler.
`default_nettype none
package tts_pkg;

    localparam int TASK_SLOTS_DEFAULT = 8;
    localparam int MAX_RESULTS        = 8;
    localparam int HANDLE_W           = 16;
    localparam int DELAY_W            = 16;
    localparam int PERIOD_W           = 16;
    localparam int PEND_W             = 8;
    localparam int SLOT_W             = 3;
    localparam int OP_W               = 2;
    localparam int STATUS_W           = 2;
    localparam int S_TDATA_W          = 56;
    localparam int M_TDATA_W          = 24;

    localparam logic [PEND_W-1:0] PENDING_MAX = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DELETE   = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_FREE    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_TICK,
        WR_ADD,
        WR_CLEAR,
        WR_DISPATCH
    } wr_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_SHIFT,
        EM_HOLD_FINAL,
        EM_DIRECT
    } emit_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  delay;
        logic [PERIOD_W-1:0] period;
        logic [PEND_W-1:0]   pending;
    } entry_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        wr_t               wr;
        emit_t             emit;
        status_t           res_status;
        logic [SLOT_W-1:0] res_slot;
    } cmd_t;

    typedef struct packed {
        logic occupied;
        logic pending_nz;
        logic hold_valid;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

// ----- rtl/tts_datapath.sv -----
// Slot memory, slot update logic, held dispatch result and output register.
`default_nettype none
module tts_datapath #(
    parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEFAULT,
    localparam int AddrW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tts_pkg::cmd_t                  cmd,
    input  wire logic [AddrW-1:0]               addr,
    input  wire logic [tts_pkg::HANDLE_W-1:0]   task_handle,
    input  wire logic [tts_pkg::DELAY_W-1:0]    first_delay,
    input  wire logic [tts_pkg::PERIOD_W-1:0]   repeat_period,
    input  wire logic                           out_ready,
    output tts_pkg::stat_t                      stat,
    output logic                                out_valid,
    output tts_pkg::status_t                    out_status,
    output logic [tts_pkg::HANDLE_W-1:0]        out_handle,
    output logic [tts_pkg::SLOT_W-1:0]          out_slot,
    output logic                                out_last
);

    localparam int SlotW = tts_pkg::SLOT_W;

    tts_pkg::entry_t mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] valid_reg;

    tts_pkg::entry_t rd_entry_reg;
    logic            rd_valid_reg;

    logic [tts_pkg::HANDLE_W-1:0] handle_reg;
    logic [tts_pkg::DELAY_W-1:0]  delay_reg;
    logic [tts_pkg::PERIOD_W-1:0] period_reg;

    logic                         hold_valid_reg;
    logic [tts_pkg::HANDLE_W-1:0] hold_handle_reg;
    logic [SlotW-1:0]             hold_slot_reg;

    logic                         out_valid_reg;
    tts_pkg::status_t             out_status_reg;
    logic [tts_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [SlotW-1:0]             out_slot_reg;
    logic                         out_last_reg;

    tts_pkg::entry_t cur;
    tts_pkg::entry_t wr_entry;
    logic            wr_en;
    logic            wr_valid;
    logic [SlotW-1:0] addr_slot;
    logic            out_load;

    assign cur       = rd_valid_reg ? rd_entry_reg : '0;
    assign addr_slot = SlotW'(addr);
    assign wr_en     = (cmd.wr != tts_pkg::WR_NONE);
    assign out_load  = ((cmd.emit == tts_pkg::EM_SHIFT) && hold_valid_reg)
                    || (cmd.emit == tts_pkg::EM_HOLD_FINAL)
                    || (cmd.emit == tts_pkg::EM_DIRECT);

    always_comb
    begin
        wr_entry = cur;
        wr_valid = rd_valid_reg;
        case (cmd.wr)
            tts_pkg::WR_TICK:
            begin
                if (cur.handle != '0)
                begin
                    if (cur.delay == '0)
                    begin
                        if (cur.pending != tts_pkg::PENDING_MAX)
                        begin
                            wr_entry.pending = cur.pending + 1'b1;
                        end
                        if (cur.period != '0)
                        begin
                            wr_entry.delay = cur.period;
                        end
                    end
                    else
                    begin
                        wr_entry.delay = cur.delay - 1'b1;
                    end
                end
            end
            tts_pkg::WR_ADD:
            begin
                wr_entry.handle  = handle_reg;
                wr_entry.delay   = delay_reg;
                wr_entry.period  = period_reg;
                wr_entry.pending = '0;
                wr_valid         = 1'b1;
            end
            tts_pkg::WR_CLEAR:
            begin
                wr_valid = 1'b0;
            end
            tts_pkg::WR_DISPATCH:
            begin
                wr_entry.pending = cur.pending - 1'b1;
                wr_valid         = (cur.period != '0);
            end
            default:
            begin
                wr_entry = cur;
                wr_valid = rd_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_entry;
        end
        if (cmd.rd_en)
        begin
            rd_entry_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[addr] <= wr_valid;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            handle_reg <= task_handle;
            delay_reg  <= first_delay;
            period_reg <= repeat_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            hold_handle_reg <= '0;
            hold_slot_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= tts_pkg::ST_OK;
            out_handle_reg  <= '0;
            out_slot_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.emit)
                tts_pkg::EM_SHIFT:
                begin
                    if (hold_valid_reg)
                    begin
                        out_status_reg <= tts_pkg::ST_OK;
                        out_handle_reg <= hold_handle_reg;
                        out_slot_reg   <= hold_slot_reg;
                        out_last_reg   <= 1'b0;
                    end
                    hold_valid_reg  <= 1'b1;
                    hold_handle_reg <= cur.handle;
                    hold_slot_reg   <= addr_slot;
                end
                tts_pkg::EM_HOLD_FINAL:
                begin
                    out_status_reg <= tts_pkg::ST_OK;
                    out_handle_reg <= hold_handle_reg;
                    out_slot_reg   <= hold_slot_reg;
                    out_last_reg   <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end
                tts_pkg::EM_DIRECT:
                begin
                    out_status_reg <= cmd.res_status;
                    out_handle_reg <= '0;
                    out_slot_reg   <= cmd.res_slot;
                    out_last_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.occupied   = (cur.handle != '0);
    assign stat.pending_nz = (cur.pending != '0);
    assign stat.hold_valid = hold_valid_reg;
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_slot   = out_slot_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/tts_controller.sv -----
// Operation sequencer that walks the slot table and issues datapath commands.
`default_nettype none
module tts_controller #(
    parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEFAULT,
    localparam int AddrW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire tts_pkg::op_t                  operation,
    input  wire logic [tts_pkg::SLOT_W-1:0]    target_slot,
    input  wire tts_pkg::stat_t                stat,
    output logic                               in_ready,
    output tts_pkg::cmd_t                      cmd,
    output logic [AddrW-1:0]                   addr
);

    localparam int CntW  = (tts_pkg::MAX_RESULTS > 1) ? $clog2(tts_pkg::MAX_RESULTS) : 1;
    localparam int SlotW = tts_pkg::SLOT_W;
    localparam logic [AddrW-1:0] LastAddr = AddrW'(TASK_SLOTS - 1);
    localparam logic [CntW-1:0]  LastCnt  = CntW'(tts_pkg::MAX_RESULTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_PROC,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    tts_pkg::op_t      op_reg, op_next;
    logic [SlotW-1:0]  target_reg, target_next;
    logic [AddrW-1:0]  addr_reg, addr_next;
    logic [CntW-1:0]   count_reg, count_next;

    logic accept;
    logic at_last;
    logic target_in_range;

    assign in_ready        = (state_reg == S_IDLE);
    assign accept          = in_valid && in_ready;
    assign at_last         = (addr_reg == LastAddr);
    assign target_in_range = (int'(target_slot) < TASK_SLOTS);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        target_next = target_reg;
        addr_next   = addr_reg;
        count_next  = count_reg;

        cmd            = '0;
        cmd.capture    = accept;
        cmd.wr         = tts_pkg::WR_NONE;
        cmd.emit       = tts_pkg::EM_NONE;
        cmd.res_status = tts_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = operation;
                    target_next = target_slot;
                    addr_next   = '0;
                    count_next  = '0;
                    state_next  = S_READ;
                    if (operation == tts_pkg::OP_DELETE)
                    begin
                        addr_next = AddrW'(target_slot);
                        if (!target_in_range)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_PROC;
            end
            S_PROC:
            begin
                case (op_reg)
                    tts_pkg::OP_TICK:
                    begin
                        cmd.wr = tts_pkg::WR_TICK;
                        if (at_last)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            addr_next  = addr_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    tts_pkg::OP_ADD:
                    begin
                        if (!stat.occupied)
                        begin
                            if (!stat.out_busy)
                            begin
                                cmd.wr         = tts_pkg::WR_ADD;
                                cmd.emit       = tts_pkg::EM_DIRECT;
                                cmd.res_status = tts_pkg::ST_OK;
                                cmd.res_slot   = SlotW'(addr_reg);
                                state_next     = S_IDLE;
                            end
                        end
                        else if (at_last)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            addr_next  = addr_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    tts_pkg::OP_DELETE:
                    begin
                        if (!stat.out_busy)
                        begin
                            cmd.wr         = tts_pkg::WR_CLEAR;
                            cmd.emit       = tts_pkg::EM_DIRECT;
                            cmd.res_status = stat.occupied ? tts_pkg::ST_OK : tts_pkg::ST_FREE;
                            cmd.res_slot   = target_reg;
                            state_next     = S_IDLE;
                        end
                    end
                    tts_pkg::OP_DISPATCH:
                    begin
                        if (stat.pending_nz)
                        begin
                            if (!stat.out_busy)
                            begin
                                cmd.wr     = tts_pkg::WR_DISPATCH;
                                cmd.emit   = tts_pkg::EM_SHIFT;
                                count_next = count_reg + 1'b1;
                                if (at_last || (count_reg == LastCnt))
                                begin
                                    state_next = S_FINISH;
                                end
                                else
                                begin
                                    addr_next  = addr_reg + 1'b1;
                                    state_next = S_READ;
                                end
                            end
                        end
                        else if (at_last)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            addr_next  = addr_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                    case (op_reg)
                        tts_pkg::OP_TICK:
                        begin
                            cmd.emit       = tts_pkg::EM_DIRECT;
                            cmd.res_status = tts_pkg::ST_OK;
                        end
                        tts_pkg::OP_ADD:
                        begin
                            cmd.emit       = tts_pkg::EM_DIRECT;
                            cmd.res_status = tts_pkg::ST_FULL;
                        end
                        tts_pkg::OP_DELETE:
                        begin
                            cmd.emit       = tts_pkg::EM_DIRECT;
                            cmd.res_status = tts_pkg::ST_FREE;
                            cmd.res_slot   = target_reg;
                        end
                        tts_pkg::OP_DISPATCH:
                        begin
                            if (stat.hold_valid)
                            begin
                                cmd.emit = tts_pkg::EM_HOLD_FINAL;
                            end
                            else
                            begin
                                cmd.emit       = tts_pkg::EM_DIRECT;
                                cmd.res_status = tts_pkg::ST_NONE;
                            end
                        end
                        default:
                        begin
                            cmd.emit = tts_pkg::EM_NONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= tts_pkg::OP_TICK;
            target_reg <= '0;
            addr_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            target_reg <= target_next;
            addr_reg   <= addr_next;
            count_reg  <= count_next;
        end
    end

    assign addr = addr_reg;

endmodule
`default_nettype wire

// ----- rtl/time_triggered_task_scheduler.sv -----
// Top level of the time-triggered task scheduler: stream ports, controller and datapath.
//
// One operation is taken at a time. Tick, add and dispatch walk the slot table held
// in a single-port slot memory, visiting each slot in a read step and then an update
// step: a tick visits every slot, an add stops at the first free slot, a dispatch
// stops at the end of the table or after the eighth ready slot, and a delete reads
// only the target slot (a slot beyond the table skips the read). A result register
// that still holds an untaken transaction holds back the steps that emit a result.
// The last result sits in an output register, so the next operation is taken while it
// waits. Reset frees all slots at once through per-slot valid bits; no clearing pass
// follows reset.
`default_nettype none
module time_triggered_task_scheduler #(
    parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // task_handle[15:0], first_delay[31:16], repeat_period[47:32], target_slot[50:48]
    input  wire logic [tts_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  wire logic [tts_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // run_handle[15:0], slot_index[18:16]
    output logic [tts_pkg::M_TDATA_W-1:0]        m_tdata,
    // status[1:0]
    output logic [tts_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                 m_tlast
);

    localparam int AddrW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    tts_pkg::cmd_t                cmd;
    tts_pkg::stat_t               stat;
    logic [AddrW-1:0]             addr;
    tts_pkg::status_t             out_status;
    logic [tts_pkg::HANDLE_W-1:0] out_handle;
    logic [tts_pkg::SLOT_W-1:0]   out_slot;

    tts_controller #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .operation   (tts_pkg::op_t'(s_tuser)),
        .target_slot (s_tdata[50:48]),
        .stat        (stat),
        .in_ready    (s_tready),
        .cmd         (cmd),
        .addr        (addr)
    );

    tts_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .addr          (addr),
        .task_handle   (s_tdata[15:0]),
        .first_delay   (s_tdata[31:16]),
        .repeat_period (s_tdata[47:32]),
        .out_ready     (m_tready),
        .stat          (stat),
        .out_valid     (m_tvalid),
        .out_status    (out_status),
        .out_handle    (out_handle),
        .out_slot      (out_slot),
        .out_last      (m_tlast)
    );

    assign m_tdata = {5'b0, out_slot, out_handle};
    assign m_tuser = out_status;

endmodule
`default_nettype wire
